/* hdl/assert_macros.svh */
// Assertion shorthands shared by the block's modules.
// Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define DTW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define DTW_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* hdl/dtw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_pkg
// Shared widths, codes, defaults and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package dtw_pkg;

    localparam int DEF_MAX_FRAMES    = 128;
    localparam int DEF_MAX_COEFS     = 16;
    localparam int DEF_NUM_TEMPLATES = 8;

    localparam int OP_W        = 2;
    localparam int SLOT_W      = 3;
    localparam int FRAME_IDX_W = 7;
    localparam int COEF_IDX_W  = 4;
    localparam int COEF_W      = 16;
    localparam int DIST_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int FRAMES_W    = 8;
    localparam int NC_W        = 5;

    localparam logic [OP_W-1:0] OP_LOAD_QUERY    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_TEMPLATE = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE       = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_FRAMES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_COUNT      = 2'd2;

    localparam logic [FRAMES_W-1:0] RST_QUERY_FRAMES    = 8'd64;
    localparam logic [FRAMES_W-1:0] RST_TEMPLATE_FRAMES = 8'd64;
    localparam logic [NC_W-1:0]     RST_COEF_COUNT      = 5'd13;

    localparam logic [DIST_W-1:0] COST_CEILING = '1;

    typedef struct packed {
        logic load;
        logic start;
        logic cell_start;
        logic rd;
        logic sq;
        logic acc;
        logic root_go;
        logic commit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic nc_zero;
        logic k_last;
        logic j_last;
        logic i_last;
        logic root_busy;
        logic out_free;
    } sts_t;

    // Fold a slot number onto the template count
    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] s,
                                                   input int num);
        logic [SLOT_W-1:0] r;
        r = s;
        for (int n = 0; n < 8; n++)
        begin
            if (32'(r) >= num)
                r = SLOT_W'(32'(r) - num);
        end
        return r;
    endfunction

endpackage

/* hdl/dtw_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_if
// Request, result and configuration channels of the distance engine.
// ----------------------------------------------------------------------------
interface dtw_req_if
    import dtw_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [SLOT_W-1:0]        template_slot;
    logic [FRAME_IDX_W-1:0]   frame_index;
    logic [COEF_IDX_W-1:0]    coef_index;
    logic signed [COEF_W-1:0] coef_value;

    modport source (output valid, op, template_slot, frame_index, coef_index, coef_value,
                    input ready);
    modport sink   (input valid, op, template_slot, frame_index, coef_index, coef_value,
                    output ready);
endinterface

interface dtw_rsp_if
    import dtw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] warp_distance;
    logic              saturated;

    modport source (output valid, warp_distance, saturated, input ready);
    modport sink   (input valid, warp_distance, saturated, output ready);
endinterface

interface dtw_cfg_if
    import dtw_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/dtw_euclidean_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_euclidean_distance
// Dynamic time warping distance engine on Q7.8 feature frames.
// ----------------------------------------------------------------------------
// Coefficient loads stream at one beat per clock while the sequencer is idle.
// A compute beat holds the request side busy while the cost grid is walked one
// cell at a time; each cell runs the three-step multiply-accumulate loop over
// the coefficient stores for the clamped coefficient count nc, then the
// bit-serial square root, whose root is half the width of the squared-sum
// accumulator (18 bits with 16 coefficients). The result sits in an output
// register, so loads are taken again while it waits.
// ----------------------------------------------------------------------------
module dtw_euclidean_distance
    import dtw_pkg::*;
#(
    parameter int MAX_FRAMES    = DEF_MAX_FRAMES,
    parameter int MAX_COEFS     = DEF_MAX_COEFS,
    parameter int NUM_TEMPLATES = DEF_NUM_TEMPLATES
)(
    input  logic      clk,
    input  logic      rst_n,
    dtw_req_if.sink   req,
    dtw_rsp_if.source rsp,
    dtw_cfg_if.sink   cfg
);
    cmd_t cmd;
    sts_t sts;

    assign cfg.ready = 1'b1;

    dtw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dtw_datapath #(
        .MAX_FRAMES    (MAX_FRAMES),
        .MAX_COEFS     (MAX_COEFS),
        .NUM_TEMPLATES (NUM_TEMPLATES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (req.op),
        .template_slot (req.template_slot),
        .frame_index   (req.frame_index),
        .coef_index    (req.coef_index),
        .coef_value    (req.coef_value),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .cmd           (cmd),
        .sts           (sts),
        .rsp           (rsp)
    );

endmodule

/* hdl/dtw_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_isqrt
// Restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module dtw_isqrt
    import dtw_pkg::*;
#(
    parameter int IN_W = 36
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [IN_W-1:0]   radicand,
    output logic              busy,
    output logic [IN_W/2-1:0] root
);
    localparam int RT_W  = IN_W / 2;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic [IN_W-1:0]  val_reg,  val_next;
    logic [RT_W+1:0]  rem_reg,  rem_next;
    logic [RT_W-1:0]  root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;

    logic [RT_W+2:0]  rem_sh;
    logic [RT_W+2:0]  trial;

    always_comb
    begin
        rem_sh    = {rem_reg[RT_W:0], val_reg[IN_W-1:IN_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (go)
        begin
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(RT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[IN_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = (RT_W+2)'(rem_sh - trial);
                root_next = {root_reg[RT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = (RT_W+2)'(rem_sh);
                root_next = {root_reg[RT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

/* hdl/dtw_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// dtw_ctrl
// Sequencer: loads, per-cell coefficient loop, root wait, cell commit and result load.
// ----------------------------------------------------------------------------
module dtw_ctrl
    import dtw_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic [OP_W-1:0] req_op,
    output logic            req_ready,
    input  sts_t            sts,
    output cmd_t            cmd
);
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CSTART  = 4'd1;
    localparam logic [3:0] ST_RD      = 4'd2;
    localparam logic [3:0] ST_SQ      = 4'd3;
    localparam logic [3:0] ST_ACC     = 4'd4;
    localparam logic [3:0] ST_SQRT_GO = 4'd5;
    localparam logic [3:0] ST_ROOT    = 4'd6;
    localparam logic [3:0] ST_CELL    = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       fire;

    assign req_ready = (state_reg == ST_IDLE);
    assign fire      = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (fire)
                begin
                    if (req_op == OP_LOAD_QUERY || req_op == OP_LOAD_TEMPLATE)
                        cmd.load = 1'b1;
                    else if (req_op == OP_COMPUTE)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_CSTART;
                    end
                end
            end
            ST_CSTART:
            begin
                cmd.cell_start = 1'b1;
                state_next     = sts.nc_zero ? ST_SQRT_GO : ST_RD;
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.k_last ? ST_SQRT_GO : ST_RD;
            end
            ST_SQRT_GO:
            begin
                cmd.root_go = 1'b1;
                state_next  = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (!sts.root_busy)
                    state_next = ST_CELL;
            end
            ST_CELL:
            begin
                cmd.commit = 1'b1;
                state_next = (sts.i_last && sts.j_last) ? ST_DONE : ST_CSTART;
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `DTW_ASSERT(a_out_load_free, cmd.out_load |-> sts.out_free, "result loaded over a pending beat")
    `DTW_ASSERT(a_start_then_cell, cmd.start |=> cmd.cell_start, "compute did not enter first cell")

endmodule

/* hdl/dtw_datapath.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// dtw_datapath
// Coefficient stores, squared-difference accumulator, row buffers and
// saturating cell cost update.
// ----------------------------------------------------------------------------
module dtw_datapath
    import dtw_pkg::*;
#(
    parameter int MAX_FRAMES    = DEF_MAX_FRAMES,
    parameter int MAX_COEFS     = DEF_MAX_COEFS,
    parameter int NUM_TEMPLATES = DEF_NUM_TEMPLATES
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [OP_W-1:0]          op,
    input  logic [SLOT_W-1:0]        template_slot,
    input  logic [FRAME_IDX_W-1:0]   frame_index,
    input  logic [COEF_IDX_W-1:0]    coef_index,
    input  logic signed [COEF_W-1:0] coef_value,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    dtw_rsp_if.source                rsp
);
    localparam int QDEPTH = MAX_FRAMES * MAX_COEFS;
    localparam int TDEPTH = NUM_TEMPLATES * MAX_FRAMES * MAX_COEFS;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int TA_W   = $clog2(TDEPTH);
    localparam int FW     = $clog2(MAX_FRAMES);
    localparam int CW     = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
    localparam int KW     = $clog2(MAX_COEFS + 1);
    localparam int CB     = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 0;
    localparam int SUM_W  = 32 + 2 * ((CB + 1) / 2);
    localparam int RT_W   = SUM_W / 2;

    logic signed [COEF_W-1:0] query_mem [QDEPTH];
    logic signed [COEF_W-1:0] tmpl_mem  [TDEPTH];
    logic [DIST_W-1:0]        row_a     [MAX_FRAMES];
    logic [DIST_W-1:0]        row_b     [MAX_FRAMES];

    logic [FRAMES_W-1:0] qframes_reg;
    logic [FRAMES_W-1:0] tframes_reg;
    logic [NC_W-1:0]     ncount_reg;

    logic [FW-1:0]       qlast_reg, tlast_reg;
    logic [KW-1:0]       nc_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [FW-1:0]       i_reg, j_reg;
    logic [KW-1:0]       k_reg;
    logic                bank_reg;

    logic signed [COEF_W-1:0] q_rd_reg, t_rd_reg;
    logic [DIST_W-1:0]   prod_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [DIST_W-1:0]   up_reg, left_reg, upleft_reg, base_reg, cost_reg;
    logic                sat_reg;

    logic                out_valid_reg;
    logic [DIST_W-1:0]   out_dist_reg;
    logic                out_sat_reg;

    logic [FW-1:0]       qlast_next, tlast_next;
    logic [KW-1:0]       nc_next;
    logic [SLOT_W-1:0]   slot_in;
    logic                load_ok;
    logic [QA_W-1:0]     q_waddr, q_raddr;
    logic [TA_W-1:0]     t_waddr, t_raddr;
    logic [CW-1:0]       k_idx;
    logic signed [COEF_W:0]   diff;
    logic signed [2*COEF_W+1:0] sq;
    logic [DIST_W-1:0]   min_ul, min3, base_next;
    logic [RT_W-1:0]     root;
    logic                root_busy;
    logic [DIST_W:0]     cell_sum;
    logic                cell_hit;
    logic [DIST_W-1:0]   cell_cost;

    function automatic logic [FW-1:0] frames_last(input logic [FRAMES_W-1:0] n);
        logic [FW-1:0] r;
        if (n == '0)
            r = '0;
        else if (32'(n) > MAX_FRAMES)
            r = FW'(MAX_FRAMES - 1);
        else
            r = FW'(32'(n) - 1);
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qframes_reg <= RST_QUERY_FRAMES;
            tframes_reg <= RST_TEMPLATE_FRAMES;
            ncount_reg  <= RST_COEF_COUNT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_QUERY_FRAMES:    qframes_reg <= cfg_data;
                REG_TEMPLATE_FRAMES: tframes_reg <= cfg_data;
                REG_COEF_COUNT:      ncount_reg  <= cfg_data[NC_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        qlast_next = frames_last(qframes_reg);
        tlast_next = frames_last(tframes_reg);
        if (32'(ncount_reg) > MAX_COEFS)
            nc_next = KW'(MAX_COEFS);
        else
            nc_next = KW'(ncount_reg);
        slot_in = wrap_slot(template_slot, NUM_TEMPLATES);
        load_ok = (32'(frame_index) < MAX_FRAMES) && (32'(coef_index) < MAX_COEFS);
        q_waddr = QA_W'(32'(frame_index) * MAX_COEFS + 32'(coef_index));
        t_waddr = TA_W'((32'(slot_in) * MAX_FRAMES + 32'(frame_index)) * MAX_COEFS
                        + 32'(coef_index));
        k_idx   = k_reg[CW-1:0];
        q_raddr = QA_W'(32'(i_reg) * MAX_COEFS + 32'(k_idx));
        t_raddr = TA_W'((32'(slot_reg) * MAX_FRAMES + 32'(j_reg)) * MAX_COEFS
                        + 32'(k_idx));
        diff    = (COEF_W+1)'(q_rd_reg) - (COEF_W+1)'(t_rd_reg);
        sq      = (2*COEF_W+2)'(diff) * (2*COEF_W+2)'(diff);
    end

    // coefficient stores
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok && op == OP_LOAD_QUERY)
            query_mem[q_waddr] <= coef_value;
        if (cmd.rd)
            q_rd_reg <= query_mem[q_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok && op == OP_LOAD_TEMPLATE)
            tmpl_mem[t_waddr] <= coef_value;
        if (cmd.rd)
            t_rd_reg <= tmpl_mem[t_raddr];
    end

    // row buffers: bank_reg picks the row being written, the other is the row above
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !bank_reg)
            row_a[j_reg] <= cell_cost;
        if (cmd.cell_start && bank_reg)
            up_reg <= row_a[j_reg];
        else if (cmd.cell_start)
            up_reg <= row_b[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && bank_reg)
            row_b[j_reg] <= cell_cost;
    end

    // neighbour selection
    always_comb
    begin
        min_ul = (left_reg < upleft_reg) ? left_reg : upleft_reg;
        min3   = (min_ul < up_reg) ? min_ul : up_reg;
        if (i_reg == '0 && j_reg == '0)
            base_next = '0;
        else if (i_reg == '0)
            base_next = left_reg;
        else if (j_reg == '0)
            base_next = up_reg;
        else
            base_next = min3;
        cell_sum  = {1'b0, base_reg} + {1'b0, DIST_W'(root)};
        cell_hit  = cell_sum >= {1'b0, COST_CEILING};
        cell_cost = cell_hit ? COST_CEILING : cell_sum[DIST_W-1:0];
    end

    dtw_isqrt #(
        .IN_W (SUM_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.root_go),
        .radicand (sum_reg),
        .busy     (root_busy),
        .root     (root)
    );

    // grid walk and accumulation
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            qlast_reg <= qlast_next;
            tlast_reg <= tlast_next;
            nc_reg    <= nc_next;
            slot_reg  <= wrap_slot(template_slot, NUM_TEMPLATES);
            i_reg     <= '0;
            j_reg     <= '0;
            bank_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            if (j_reg == tlast_reg)
            begin
                j_reg    <= '0;
                i_reg    <= i_reg + 1'b1;
                bank_reg <= ~bank_reg;
            end
            else
                j_reg <= j_reg + 1'b1;
        end

        if (cmd.cell_start)
        begin
            k_reg   <= '0;
            sum_reg <= '0;
        end
        else if (cmd.acc)
        begin
            k_reg   <= k_reg + 1'b1;
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        end

        if (cmd.sq)
            prod_reg <= sq[DIST_W-1:0];
        if (cmd.root_go)
            base_reg <= base_next;
        if (cmd.commit)
        begin
            left_reg   <= cell_cost;
            upleft_reg <= up_reg;
            cost_reg   <= cell_cost;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sat_reg <= 1'b0;
        else if (cmd.start)
            sat_reg <= 1'b0;
        else if (cmd.commit && cell_hit)
            sat_reg <= 1'b1;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_dist_reg <= cost_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.warp_distance = out_dist_reg;
    assign rsp.saturated     = out_sat_reg;

    always_comb
    begin
        sts.nc_zero   = (nc_reg == '0);
        sts.k_last    = (k_reg == nc_reg - 1'b1);
        sts.j_last    = (j_reg == tlast_reg);
        sts.i_last    = (i_reg == qlast_reg);
        sts.root_busy = root_busy;
        sts.out_free  = !out_valid_reg || rsp.ready;
    end

    `DTW_ASSERT(a_sat_cleared, cmd.start |=> !sat_reg, "saturation flag not cleared on compute")
    `DTW_ASSERT(a_root_runs, cmd.root_go |=> root_busy, "square root unit did not start")

endmodule

/* tb/dtw_distance_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_distance_checker
// Watches the request, result and configuration channels of the warping
// distance engine, keeps its own copy of the coefficient stores and the
// registers, predicts the distance of every compute beat and compares each
// result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module dtw_distance_checker
    import dtw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dtw_req_if   req,
    dtw_rsp_if   rsp,
    dtw_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);

    localparam int FRAMES = DEF_MAX_FRAMES;
    localparam int COEFS  = DEF_MAX_COEFS;
    localparam int SLOTS  = DEF_NUM_TEMPLATES;

    typedef struct packed {
        logic [DIST_W-1:0] cost;
        logic              sat;
    } warp_result_t;

    logic [COEF_W-1:0]   query_mem [FRAMES*COEFS];
    logic [COEF_W-1:0]   tmpl_mem  [SLOTS*FRAMES*COEFS];
    logic [FRAMES_W-1:0] query_len;
    logic [FRAMES_W-1:0] tmpl_len;
    logic [NC_W-1:0]     coef_len;
    warp_result_t        expected_warps [$];

    function automatic logic [31:0] int_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] frame_cost(input int qf, input int slot, input int tf,
                                               input int nc);
        longint unsigned sum;
        longint          d;
        int              a;
        int              b;
        sum = 0;
        for (int k = 0; k < nc; k++)
        begin
            a = $signed(query_mem[qf*COEFS + k]);
            b = $signed(tmpl_mem[(slot*FRAMES + tf)*COEFS + k]);
            d = a - b;
            if (d < 0)
                d = -d;
            sum += d * d;
        end
        return int_root(sum);
    endfunction

    // Bit 32 flags that the ceiling was hit
    function automatic logic [32:0] capped_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, COST_CEILING})
            return {1'b1, COST_CEILING};
        return {1'b0, s[31:0]};
    endfunction

    function automatic int clamp_len(input logic [FRAMES_W-1:0] n);
        if (n == 0)
            return 1;
        if (n > FRAMES)
            return FRAMES;
        return int'(n);
    endfunction

    function automatic warp_result_t predict_warp(input logic [SLOT_W-1:0] slot_in);
        logic [31:0]  prev_row [FRAMES];
        logic [31:0]  cur_row  [FRAMES];
        logic [32:0]  t;
        logic [31:0]  best;
        logic         sat;
        int           qn;
        int           tn;
        int           nc;
        int           slot;
        warp_result_t r;
        slot = slot_in % SLOTS;
        qn = clamp_len(query_len);
        tn = clamp_len(tmpl_len);
        nc = (coef_len > COEFS) ? COEFS : coef_len;
        sat = 1'b0;
        prev_row[0] = frame_cost(0, slot, 0, nc);
        for (int j = 1; j < tn; j++)
        begin
            t = capped_sum(prev_row[j-1], frame_cost(0, slot, j, nc));
            sat |= t[32];
            prev_row[j] = t[31:0];
        end
        for (int i = 1; i < qn; i++)
        begin
            t = capped_sum(prev_row[0], frame_cost(i, slot, 0, nc));
            sat |= t[32];
            cur_row[0] = t[31:0];
            for (int j = 1; j < tn; j++)
            begin
                best = prev_row[j];
                if (cur_row[j-1] < best)
                    best = cur_row[j-1];
                if (prev_row[j-1] < best)
                    best = prev_row[j-1];
                t = capped_sum(best, frame_cost(i, slot, j, nc));
                sat |= t[32];
                cur_row[j] = t[31:0];
            end
            for (int j = 0; j < tn; j++)
                prev_row[j] = cur_row[j];
        end
        r.cost = prev_row[tn-1];
        r.sat  = sat;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        warp_result_t want;
        if (!rst_n)
        begin
            query_len  = RST_QUERY_FRAMES;
            tmpl_len   = RST_TEMPLATE_FRAMES;
            coef_len   = RST_COEF_COUNT;
            fail_count = 0;
            pending    = 0;
            expected_warps.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_QUERY_FRAMES:    query_len = cfg.data;
                    REG_TEMPLATE_FRAMES: tmpl_len  = cfg.data;
                    REG_COEF_COUNT:      coef_len  = cfg.data[NC_W-1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                case (req.op)
                    OP_LOAD_QUERY:
                        query_mem[req.frame_index*COEFS + req.coef_index] = req.coef_value;
                    OP_LOAD_TEMPLATE:
                        tmpl_mem[((req.template_slot % SLOTS)*FRAMES + req.frame_index)*COEFS
                                 + req.coef_index] = req.coef_value;
                    OP_COMPUTE:
                        expected_warps.push_back(predict_warp(req.template_slot));
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_warps.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat cost=%h sat=%b", $realtime,
                             rsp.warp_distance, rsp.saturated);
                end
                else
                begin
                    want = expected_warps.pop_front();
                    if (rsp.warp_distance !== want.cost)
                    begin
                        fail_count++;
                        $display("%0t: warp_distance expected %h actual %h", $realtime,
                                 want.cost, rsp.warp_distance);
                    end
                    if (rsp.saturated !== want.sat)
                    begin
                        fail_count++;
                        $display("%0t: saturated expected %b actual %b", $realtime,
                                 want.sat, rsp.saturated);
                    end
                end
            end
            pending = expected_warps.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the warping distance engine: coefficient loads, register
// settings and compute beats, directed first and then random, with idling
// on both sides and one long result stall. Checking lives in the checker.
// ----------------------------------------------------------------------------
module testbench;
    import dtw_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int FRAMES     = DEF_MAX_FRAMES;
    localparam int COEFS      = DEF_MAX_COEFS;
    localparam int ITEM_GOAL  = 1750;
    localparam int HOLD_LEN   = 400;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   src_idle;
    int   rcv_idle;
    int   items_sent;
    int   hold_left;
    bit   pressure_req;
    bit   pressure_done;
    bit   query_seen [FRAMES*COEFS];
    bit   tmpl_seen  [DEF_NUM_TEMPLATES*FRAMES*COEFS];

    dtw_req_if req_ch ();
    dtw_rsp_if rsp_ch ();
    dtw_cfg_if cfg_ch ();

    dtw_euclidean_distance dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    dtw_distance_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (pressure_req && !pressure_done)
            begin
                hold_left = HOLD_LEN;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic int clamp_len(input int n);
        if (n == 0)
            return 1;
        return (n > FRAMES) ? FRAMES : n;
    endfunction

    task automatic send_req(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                            input logic [FRAME_IDX_W-1:0] fr,
                            input logic [COEF_IDX_W-1:0] ci, input logic [COEF_W-1:0] val);
        @(negedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.op            <= op;
        req_ch.template_slot <= slot;
        req_ch.frame_index   <= fr;
        req_ch.coef_index    <= ci;
        req_ch.coef_value    <= val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        if (op == OP_LOAD_QUERY)
            query_seen[fr*COEFS + ci] = 1'b1;
        else if (op == OP_LOAD_TEMPLATE)
            tmpl_seen[(slot*FRAMES + fr)*COEFS + ci] = 1'b1;
    endtask

    // Drain all results, let the engine settle, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_regs(input int qf, input int tf, input int nc);
        write_reg(REG_QUERY_FRAMES, CFG_DATA_W'(qf));
        write_reg(REG_TEMPLATE_FRAMES, CFG_DATA_W'(tf));
        write_reg(REG_COEF_COUNT, CFG_DATA_W'(nc));
    endtask

    // Load every entry a compute will read that has not been written yet
    task automatic fill_span(input logic [SLOT_W-1:0] slot, input int qf, input int tf,
                             input int nc);
        int qn;
        int tn;
        int cn;
        qn = clamp_len(qf);
        tn = clamp_len(tf);
        cn = (nc > COEFS) ? COEFS : nc;
        for (int f = 0; f < qn; f++)
            for (int c = 0; c < cn; c++)
                if (!query_seen[f*COEFS + c])
                    send_req(OP_LOAD_QUERY, 0, FRAME_IDX_W'(f), COEF_IDX_W'(c),
                             pick_coef());
        for (int f = 0; f < tn; f++)
            for (int c = 0; c < cn; c++)
                if (!tmpl_seen[(slot*FRAMES + f)*COEFS + c])
                    send_req(OP_LOAD_TEMPLATE, slot, FRAME_IDX_W'(f), COEF_IDX_W'(c),
                             pick_coef());
    endtask

    initial
    begin
        int qf;
        int tf;
        int nc;
        logic [SLOT_W-1:0] slot;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_LOAD_QUERY;
        req_ch.template_slot = '0;
        req_ch.frame_index = '0;
        req_ch.coef_index = '0;
        req_ch.coef_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_QUERY_FRAMES;
        cfg_ch.data = '0;
        rsp_ch.ready = 1'b0;
        src_idle = 27;
        rcv_idle = 63;
        items_sent = 0;
        hold_left = 0;
        pressure_req = 1'b0;
        pressure_done = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Opposite extremes, one frame each
        send_req(OP_LOAD_QUERY, 0, 0, 0, 16'h8000);
        send_req(OP_LOAD_TEMPLATE, 0, 0, 0, 16'h7FFF);
        send_req(OP_LOAD_TEMPLATE, 7, 127, 15, 16'h7FFF);
        send_req(OP_LOAD_QUERY, 0, 127, 15, 16'h8000);
        send_req(OP_UNUSED, 5, 3, 3, 16'h1234);
        set_regs(1, 1, 1);
        send_req(OP_COMPUTE, 0, 0, 0, 0);
        // Zero counts: frames act as one, distances vanish
        set_regs(0, 0, 0);
        send_req(OP_COMPUTE, 0, 0, 0, 0);
        send_req(OP_COMPUTE, 7, 0, 0, 0);
        set_regs(2, 3, 2);
        fill_span(3, 2, 3, 2);
        send_req(OP_COMPUTE, 3, 127, 15, 16'hFFFF);

        while (items_sent < ITEM_GOAL)
        begin
            if (items_sent < ITEM_GOAL / 3)
            begin
                src_idle = 27;
                rcv_idle = 63;
            end
            else if (items_sent < 2 * ITEM_GOAL / 3)
            begin
                src_idle = 63;
                rcv_idle = 27;
            end
            else
            begin
                src_idle = 0;
                rcv_idle = 0;
            end
            qf = $urandom_range(1, 6);
            tf = $urandom_range(1, 6);
            nc = $urandom_range(1, 16);
            case ($urandom_range(39))
                0: begin qf = 255; tf = $urandom_range(1, 3); nc = 1; end
                1: begin qf = 2; tf = 200; nc = 2; end
                2: nc = $urandom_range(17, 31);
                3: begin qf = 0; tf = 0; end
                4: nc = 0;
                5: begin qf = 128; tf = 1; nc = 1; end
                default: ;
            endcase
            slot = SLOT_W'($urandom);
            set_regs(qf, tf, nc);
            fill_span(slot, qf, tf, nc);
            // Fresh content inside the span, then some noise
            repeat ($urandom_range(0, 6))
            begin
                if ($urandom_range(1))
                    send_req(OP_LOAD_QUERY, SLOT_W'($urandom),
                             FRAME_IDX_W'($urandom_range(0, clamp_len(qf) - 1)),
                             COEF_IDX_W'($urandom_range(0, 15)), pick_coef());
                else
                    send_req(OP_LOAD_TEMPLATE, slot,
                             FRAME_IDX_W'($urandom_range(0, clamp_len(tf) - 1)),
                             COEF_IDX_W'($urandom_range(0, 15)), pick_coef());
            end
            repeat ($urandom_range(0, 2))
                send_req($urandom_range(1) ? OP_UNUSED : OP_LOAD_QUERY, SLOT_W'($urandom),
                         FRAME_IDX_W'($urandom), COEF_IDX_W'($urandom), COEF_W'($urandom));
            if (src_idle == 0 && !pressure_done)
            begin
                pressure_req = 1'b1;
                send_req(OP_COMPUTE, slot, FRAME_IDX_W'($urandom), COEF_IDX_W'($urandom),
                         COEF_W'($urandom));
                send_req(OP_LOAD_QUERY, 0, 0, 0, pick_coef());
                send_req(OP_COMPUTE, slot, FRAME_IDX_W'($urandom), COEF_IDX_W'($urandom),
                         COEF_W'($urandom));
            end
            send_req(OP_COMPUTE, slot, FRAME_IDX_W'($urandom), COEF_IDX_W'($urandom),
                     COEF_W'($urandom));
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
